/* rtl/core/qdt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qdt_pkg
// Shared types, constants and helpers of the quadrature decoder with timing.
// ---------------------------------------------------------------------------
package qdt_pkg;

	// Timing input
	localparam int TIME_BITS      = 28;
	localparam int DEBOUNCE_TICKS = 0;
	localparam int ELAPSED_W      = 28;
	// Wide enough for the masked elapsed value plus the largest debounce offset
	localparam int TICK_W         = ((TIME_BITS > 10) ? TIME_BITS : 10) + 1;

	// Stream widths
	localparam int IN_W  = 32;
	localparam int OUT_W = 168;

	// Register file
	localparam int  PADDR_W              = 3;
	localparam logic REG_COUNT_EVERY_STEP = 1'b0;

	// Queue between front and back
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

	// Command codes
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_TRANSITION = 2'd0;
	localparam cmd_t CMD_CAPTURE    = 2'd1;
	localparam cmd_t CMD_ZERO       = 2'd2;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	// One classified transaction, as queued between front and back
	typedef struct packed {
		cmd_t              cmd;
		logic              step_up;
		logic              step_dn;
		logic              detent;
		logic              dir_wr;
		dir_t              dir_val;
		logic              lvl_a;
		logic              lvl_b;
		logic [TICK_W-1:0] ticks;
	} op_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	// Phase numbering: 0 (0,0), 1 (1,0), 2 (1,1), 3 (0,1)
	function automatic logic [1:0] phase_of(input logic a, input logic b);
		logic [1:0] ph;
		if (!a) begin
			ph = b ? 2'd3 : 2'd0;
		end else begin
			ph = b ? 2'd2 : 2'd1;
		end
		return ph;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/qdt_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qdt_front
// Accepts input transactions and classifies each Gray transition.
// ---------------------------------------------------------------------------
module qdt_front (
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [qdt_pkg::IN_W-1:0]    s_tdata,   // prev_a, prev_b, new_a, new_b, elapsed
	input  wire qdt_pkg::cmd_t               s_tuser,   // command
	input  wire qdt_pkg::q_stat_t            q_stat,
	output logic                             push,
	output qdt_pkg::op_t                     op
);

	logic                          prev_a, prev_b, new_a, new_b;
	logic [qdt_pkg::ELAPSED_W-1:0] elapsed;
	logic [1:0]                    ph_from, ph_to;
	logic                          is_tr;

	assign prev_a  = s_tdata[0];
	assign prev_b  = s_tdata[1];
	assign new_a   = s_tdata[2];
	assign new_b   = s_tdata[3];
	assign elapsed = s_tdata[31:4];

	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && s_tready;

	assign ph_from = qdt_pkg::phase_of(prev_a, prev_b);
	assign ph_to   = qdt_pkg::phase_of(new_a, new_b);
	assign is_tr   = (s_tuser == qdt_pkg::CMD_TRANSITION);

	always_comb begin
		op         = '0;
		op.cmd     = s_tuser;
		op.lvl_a   = new_a;
		op.lvl_b   = new_b;
		op.ticks   = qdt_pkg::TICK_W'(elapsed[qdt_pkg::TIME_BITS-1:0])
			+ qdt_pkg::TICK_W'(qdt_pkg::DEBOUNCE_TICKS);
		op.dir_val = qdt_pkg::DIR_NONE;
		if (is_tr) begin
			op.step_up = (ph_to == 2'(ph_from + 2'd1));
			op.step_dn = (ph_to == 2'(ph_from - 2'd1));
			// Detent completes entering phase 2 from either side
			op.detent  = (ph_to == 2'd2) && (ph_from == 2'd1 || ph_from == 2'd3);
			if (op.detent) begin
				op.dir_wr  = 1'b1;
				op.dir_val = qdt_pkg::DIR_NONE;
			end else if (ph_from == 2'd2 && ph_to == 2'd3) begin
				op.dir_wr  = 1'b1;
				op.dir_val = qdt_pkg::DIR_UP;
			end else if (ph_from == 2'd2 && ph_to == 2'd1) begin
				op.dir_wr  = 1'b1;
				op.dir_val = qdt_pkg::DIR_DOWN;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/qdt_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qdt_queue
// Short first-in first-out queue of classified transactions.
// ---------------------------------------------------------------------------
module qdt_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire qdt_pkg::op_t      din,
	input  wire logic              pop,
	output qdt_pkg::op_t           dout,
	output qdt_pkg::q_stat_t       q_stat
);

	qdt_pkg::op_t                  store_q [qdt_pkg::QDEPTH];
	logic [qdt_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [qdt_pkg::QCNT_W-1:0]    count_q;

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == qdt_pkg::QCNT_W'(qdt_pkg::QDEPTH));
	assign dout         = store_q[rd_ptr_q];

	function automatic logic [qdt_pkg::QPTR_W-1:0] next_ptr(
		input logic [qdt_pkg::QPTR_W-1:0] p);
		logic [qdt_pkg::QPTR_W-1:0] n;
		if (p == qdt_pkg::QPTR_W'(qdt_pkg::QDEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + 1'b1;
		end
		return n;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/qdt_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qdt_back
// Applies queued transactions to the counter state and registers results.
// ---------------------------------------------------------------------------
module qdt_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      count_every_step,
	input  wire qdt_pkg::op_t              op,
	input  wire logic                      op_valid,
	output logic                           pop,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [qdt_pkg::OUT_W-1:0]      m_tdata
);

	logic [31:0]   step_q, zero_q, capt_q, intv_q;
	logic [30:0]   win_q, pend_q;
	qdt_pkg::dir_t dir_q;
	logic [1:0]    lvl_q;

	logic [31:0]   step_n, zero_n, capt_n, intv_n;
	logic [30:0]   win_n, pend_n;
	qdt_pkg::dir_t dir_n;
	logic [1:0]    lvl_n;

	logic          out_valid_q;
	logic [qdt_pkg::OUT_W-1:0] out_data_q;

	logic          advance;
	logic [31:0]   pend_sum, win_sum;
	logic [30:0]   t_x1, t, win_sat;
	logic          counted;
	logic [31:0]   change;
	logic [30:0]   wtime;
	logic          rate_valid;

	assign advance  = !out_valid_q || m_tready;
	assign pop      = op_valid && advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Step time: x1 mode folds in the ticks of skipped steps
	assign pend_sum = {1'b0, pend_q} + 32'(op.ticks);
	assign t_x1     = (pend_sum > {1'b0, qdt_pkg::SAT31}) ? qdt_pkg::SAT31 : pend_sum[30:0];
	assign t        = count_every_step ? 31'(op.ticks) : t_x1;
	assign win_sum  = {1'b0, win_q} + {1'b0, t};
	assign win_sat  = (win_sum > {1'b0, qdt_pkg::SAT31}) ? qdt_pkg::SAT31 : win_sum[30:0];

	always_comb begin
		if (count_every_step) begin
			counted = op.step_up || op.step_dn;
		end else begin
			counted = op.detent && ((op.step_up && dir_q == qdt_pkg::DIR_UP) ||
				(op.step_dn && dir_q == qdt_pkg::DIR_DOWN));
		end
	end

	always_comb begin
		step_n     = step_q;
		zero_n     = zero_q;
		capt_n     = capt_q;
		intv_n     = intv_q;
		win_n      = win_q;
		pend_n     = pend_q;
		dir_n      = dir_q;
		lvl_n      = lvl_q;
		change     = '0;
		wtime      = win_q;
		rate_valid = 1'b0;
		case (op.cmd)
			qdt_pkg::CMD_TRANSITION: begin
				lvl_n = {op.lvl_a, op.lvl_b};
				if (!count_every_step) begin
					pend_n = t;
				end
				if (counted) begin
					step_n = op.step_up ? step_q + 32'd1 : step_q - 32'd1;
					intv_n = op.step_up ? {1'b0, t} : 32'd0 - {1'b0, t};
					pend_n = '0;
					win_n  = win_sat;
				end
				if (op.dir_wr) begin
					dir_n = op.dir_val;
				end
				wtime = win_n;
			end
			qdt_pkg::CMD_CAPTURE: begin
				win_n      = '0;
				change     = step_q - capt_q;
				capt_n     = step_q;
				rate_valid = (change != 32'd0) && (win_q != qdt_pkg::SAT31);
			end
			qdt_pkg::CMD_ZERO: begin
				zero_n = step_q;
			end
			default: begin
				// Unused code: report state, change nothing
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			zero_q      <= '0;
			capt_q      <= '0;
			intv_q      <= '0;
			win_q       <= '0;
			pend_q      <= '0;
			dir_q       <= qdt_pkg::DIR_NONE;
			lvl_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				step_q <= step_n;
				zero_q <= zero_n;
				capt_q <= capt_n;
				intv_q <= intv_n;
				win_q  <= win_n;
				pend_q <= pend_n;
				dir_q  <= dir_n;
				lvl_q  <= lvl_n;
			end
			if (advance) begin
				out_valid_q <= op_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= {6'd0, lvl_n[0], lvl_n[1], intv_n, rate_valid, wtime,
				change, step_n, step_n - zero_n};
		end
	end

endmodule
`default_nettype wire

/* rtl/core/quadrature_decoder_with_timing.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// quadrature_decoder_with_timing
// Quadrature step counter with x4/x1 modes, step timing and window capture.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transaction per transition report, capture or
//   zero command; s_tuser carries the command, s_tdata the A/B levels before
//   and after the transition and the elapsed sampler ticks.
//   Output stream (m_*): exactly one result per input transaction, in order:
//   position, raw count, count change, window time, rate flag, last
//   interval and the current A/B levels.
//   APB port: register 0 (byte address 0) is count_every_step; 1 selects x4
//   counting, 0 one count per detent. Write it only while the block is idle.
// Timing:
//   An accepted transaction enters a two-entry queue; the back end applies it
//   once the output register is free and registers the result, raising m_tvalid.
//   Sustained rate is one transaction per cycle while m_tready is high, set by
//   the combinational state update of the back end (two saturating adds in series).
// Reset:
//   All counts, the window, the direction latch and the levels clear to zero;
//   the mode register clears to x1 counting. No clearing pass is needed.
// Back-pressure:
//   The output register holds while m_tready is low; the queue then fills and
//   s_tready drops once both entries are taken.
// ---------------------------------------------------------------------------
module quadrature_decoder_with_timing (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Input stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [qdt_pkg::IN_W-1:0]      s_tdata,   // prev_a, prev_b, new_a, new_b, elapsed[27:0]
	input  wire logic [1:0]                    s_tuser,   // command
	// Output stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [qdt_pkg::OUT_W-1:0]          m_tdata,   // position, raw_count, count_delta,
	                                                      // window_time[30:0], rate_valid,
	                                                      // last_interval, level_a, level_b, pad
	// Configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [qdt_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	logic             count_every_step_q;
	logic             cfg_wr;
	logic             push, pop;
	qdt_pkg::op_t     op_in, op_out;
	qdt_pkg::q_stat_t q_stat;

	// Register access: word index taken from paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[2] == qdt_pkg::REG_COUNT_EVERY_STEP);
	assign prdata = (paddr[2] == qdt_pkg::REG_COUNT_EVERY_STEP) ?
		{31'd0, count_every_step_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_every_step_q <= 1'b0;
		end else if (cfg_wr) begin
			count_every_step_q <= pwdata[0];
		end
	end

	// Front: accept and classify each transaction
	qdt_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.push     (push),
		.op       (op_in)
	);

	// Queue: decouple acceptance from the state update
	qdt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (op_in),
		.pop    (pop),
		.dout   (op_out),
		.q_stat (q_stat)
	);

	// Back: update counters, timing and direction; hold the result
	qdt_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.count_every_step (count_every_step_q),
		.op               (op_out),
		.op_valid         (!q_stat.empty),
		.pop              (pop),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata)
	);

	// A rate flag implies a nonzero change and an unsaturated window
	a_rate_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[127]) |->
		(m_tdata[95:64] != 32'd0 && m_tdata[126:96] != qdt_pkg::SAT31))
		else $error("rate_valid set with zero change or saturated window");

	// A queued transaction reaches the output once the output register is free
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_stat.empty && (!m_tvalid || m_tready)) |=> m_tvalid)
		else $error("queued transaction not delivered to output register");

	// The queue never accepts while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("push into a full queue");

endmodule
`default_nettype wire

/* sim/quadrature_decoder_with_timing_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quadrature_decoder_with_timing_checker
// Watches the input, output and register ports of the decoder, predicts each
// result from an internal copy of the decoder state and compares field by
// field against what comes out, oldest expectation first.
// ---------------------------------------------------------------------------
module quadrature_decoder_with_timing_checker
	import qdt_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	input  wire logic                s_tready,
	input  wire logic [IN_W-1:0]     s_tdata,   // prev_a, prev_b, new_a, new_b, elapsed[27:0]
	input  wire logic [1:0]          s_tuser,   // command
	input  wire logic                m_tvalid,
	input  wire logic                m_tready,
	input  wire logic [OUT_W-1:0]    m_tdata,   // position, raw_count, count_delta,
	                                            // window_time[30:0], rate_valid,
	                                            // last_interval, level_a, level_b, pad
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [PADDR_W-1:0]  paddr,
	input  wire logic [31:0]         pwdata,
	input  wire logic                pready,
	output int                       errors,
	output int                       outstanding
);

	localparam logic [PADDR_W-1:0] MODE_ADDR = PADDR_W'(4 * REG_COUNT_EVERY_STEP);
	localparam logic [30:0] TICK_MASK = 31'((64'd1 << TIME_BITS) - 64'd1);

	// Phase numbering by which channels are high
	localparam logic [1:0] PH_NONE_HIGH = 2'd0;
	localparam logic [1:0] PH_A_HIGH    = 2'd1;
	localparam logic [1:0] PH_BOTH_HIGH = 2'd2;
	localparam logic [1:0] PH_B_HIGH    = 2'd3;

	typedef struct packed {
		logic [31:0] position;
		logic [31:0] raw_count;
		logic [31:0] count_delta;
		logic [30:0] window_time;
		logic        rate_valid;
		logic [31:0] last_interval;
		logic        level_a;
		logic        level_b;
	} decode_result_t;

	decode_result_t expected_results[$];

	// Decoder state copy
	logic        x4_mode;
	logic [31:0] step_count;
	logic [31:0] zero_offset;
	logic [31:0] capture_base;
	logic [30:0] window_ticks;
	logic [30:0] pending_ticks;
	logic [31:0] step_interval;
	dir_t        travel_dir;
	logic        lvl_a;
	logic        lvl_b;

	function automatic logic [30:0] sat_add31(input logic [30:0] x, input logic [30:0] y);
		logic [31:0] sum;
		sum = {1'b0, x} + {1'b0, y};
		return (sum > {1'b0, SAT31}) ? SAT31 : sum[30:0];
	endfunction

	function automatic logic [1:0] phase_num(input logic a, input logic b);
		if (!a) begin
			return b ? PH_B_HIGH : PH_NONE_HIGH;
		end
		return b ? PH_BOTH_HIGH : PH_A_HIGH;
	endfunction

	task automatic count_one(input logic up, input logic [30:0] t);
		step_count    = up ? step_count + 32'd1 : step_count - 32'd1;
		step_interval = up ? {1'b0, t} : 32'd0 - {1'b0, t};
		pending_ticks = '0;
		window_ticks  = sat_add31(window_ticks, t);
	endtask

	// Move between phases; in x1 mode only a completed detent in the latched
	// direction counts, and the skipped steps' ticks ride along
	task automatic advance_phase(input logic [1:0] from, input logic [1:0] to,
			input logic [30:0] ticks);
		logic [30:0] t;
		t = ticks;
		if (!x4_mode) begin
			t = sat_add31(t, pending_ticks);
			pending_ticks = t;
		end
		case (from)
			PH_NONE_HIGH: begin
				if (to == PH_A_HIGH && x4_mode) count_one(1'b1, t);
				else if (to == PH_B_HIGH && x4_mode) count_one(1'b0, t);
			end
			PH_A_HIGH: begin
				if (to == PH_BOTH_HIGH) begin
					if (x4_mode || travel_dir == DIR_UP) count_one(1'b1, t);
					travel_dir = DIR_NONE;
				end else if (to == PH_NONE_HIGH && x4_mode) begin
					count_one(1'b0, t);
				end
			end
			PH_BOTH_HIGH: begin
				if (to == PH_B_HIGH) begin
					if (x4_mode) count_one(1'b1, t);
					travel_dir = DIR_UP;
				end else if (to == PH_A_HIGH) begin
					if (x4_mode) count_one(1'b0, t);
					travel_dir = DIR_DOWN;
				end
			end
			default: begin
				if (to == PH_NONE_HIGH && x4_mode) begin
					count_one(1'b1, t);
				end else if (to == PH_BOTH_HIGH) begin
					if (x4_mode || travel_dir == DIR_DOWN) count_one(1'b0, t);
					travel_dir = DIR_NONE;
				end
			end
		endcase
	endtask

	task automatic predict_result(input cmd_t cmd, input logic [IN_W-1:0] data,
			output decode_result_t res);
		logic [30:0] ticks;
		logic [30:0] wtime;
		logic [31:0] change;
		logic        valid;
		change = '0;
		valid  = 1'b0;
		wtime  = window_ticks;
		case (cmd)
			CMD_TRANSITION: begin
				ticks = (31'(data[31:4]) & TICK_MASK) + 31'(DEBOUNCE_TICKS);
				lvl_a = data[2];
				lvl_b = data[3];
				advance_phase(phase_num(data[0], data[1]), phase_num(data[2], data[3]), ticks);
				wtime = window_ticks;
			end
			CMD_CAPTURE: begin
				window_ticks = '0;
				change       = step_count - capture_base;
				capture_base = step_count;
				valid        = (change != 32'd0) && (wtime != SAT31);
			end
			CMD_ZERO: begin
				zero_offset = step_count;
			end
			default: begin
				// unused code: nothing moves
			end
		endcase
		res.position      = step_count - zero_offset;
		res.raw_count     = step_count;
		res.count_delta   = change;
		res.window_time   = wtime;
		res.rate_valid    = valid;
		res.last_interval = step_interval;
		res.level_a       = lvl_a;
		res.level_b       = lvl_b;
	endtask

	task automatic flag_error(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		decode_result_t want;
		decode_result_t got;
		if (!arst_n) begin
			x4_mode        = 1'b0;
			step_count     = '0;
			zero_offset    = '0;
			capture_base   = '0;
			window_ticks   = '0;
			pending_ticks  = '0;
			step_interval  = '0;
			travel_dir     = DIR_NONE;
			lvl_a          = 1'b0;
			lvl_b          = 1'b0;
			errors         = 0;
			expected_results.delete();
			outstanding   <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == MODE_ADDR) begin
				x4_mode = pwdata[0];
			end
			if (s_tvalid && s_tready) begin
				predict_result(s_tuser, s_tdata, want);
				expected_results.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got.position      = m_tdata[31:0];
				got.raw_count     = m_tdata[63:32];
				got.count_delta   = m_tdata[95:64];
				got.window_time   = m_tdata[126:96];
				got.rate_valid    = m_tdata[127];
				got.last_interval = m_tdata[159:128];
				got.level_a       = m_tdata[160];
				got.level_b       = m_tdata[161];
				if (expected_results.size() == 0) begin
					flag_error("unexpected result, position", got.position, '0);
				end else begin
					want = expected_results.pop_front();
					if (got.position !== want.position)
						flag_error("position", got.position, want.position);
					if (got.raw_count !== want.raw_count)
						flag_error("raw_count", got.raw_count, want.raw_count);
					if (got.count_delta !== want.count_delta)
						flag_error("count_delta", got.count_delta, want.count_delta);
					if (got.window_time !== want.window_time)
						flag_error("window_time", 32'(got.window_time), 32'(want.window_time));
					if (got.rate_valid !== want.rate_valid)
						flag_error("rate_valid", 32'(got.rate_valid), 32'(want.rate_valid));
					if (got.last_interval !== want.last_interval)
						flag_error("last_interval", got.last_interval, want.last_interval);
					if (got.level_a !== want.level_a)
						flag_error("level_a", 32'(got.level_a), 32'(want.level_a));
					if (got.level_b !== want.level_b)
						flag_error("level_b", 32'(got.level_b), 32'(want.level_b));
				end
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

/* sim/quadrature_decoder_with_timing_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quadrature_decoder_with_timing_test
// Drives the decoder with directed and random transition reports, captures
// and zero commands in both counting modes, with random gaps and stalls on
// both streams; the checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module quadrature_decoder_with_timing_test;
	import qdt_pkg::*;

	localparam cmd_t CMD_UNUSED = cmd_t'(2'd3);
	localparam logic [PADDR_W-1:0] MODE_ADDR = PADDR_W'(4 * REG_COUNT_EVERY_STEP);
	localparam int RANDOM_PHASES   = 4;
	localparam int PHASE_ITEMS     = 112;
	localparam int LONG_HOLD       = 300;
	localparam int SETTLE_CYCLES   = 10;
	localparam int CYCLE_LIMIT     = 200000;
	localparam logic [27:0] ELAPSED_MAX = '1;
	// Pin pattern per phase index: bit 0 is A, bit 1 is B
	localparam logic [1:0] PINS_BY_PHASE [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata;   // prev_a, prev_b, new_a, new_b, elapsed[27:0]
	logic [1:0]         s_tuser;   // command
	logic               m_tvalid;
	logic               m_tready;
	logic [OUT_W-1:0]   m_tdata;   // position, raw_count, count_delta, window_time[30:0],
	                               // rate_valid, last_interval, level_a, level_b, pad
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int   errors;
	int   outstanding;
	int   cycles = 0;
	logic feed_steady = 1'b0;
	logic sink_steady = 1'b0;
	logic sink_hold   = 1'b0;
	logic [1:0] cur_phase = 2'd0;
	logic walk_up = 1'b1;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	quadrature_decoder_with_timing u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	quadrature_decoder_with_timing_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** quadrature_decoder_with_timing: FAILED **");
			$finish;
		end
	end

	// Offer one transaction after a random gap and hold it until taken.
	// Valid stays high into the next item when the next gap is zero.
	task automatic send_item(input cmd_t cmd, input logic [3:0] pins, input logic [27:0] el);
		int gap;
		gap = feed_steady ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {el, pins};
		do @(posedge clk); while (!s_tready);
	endtask

	// Report a transition from the current phase to the given one
	task automatic step_to(input logic [1:0] nxt, input logic [27:0] el);
		send_item(CMD_TRANSITION, {PINS_BY_PHASE[nxt], PINS_BY_PHASE[cur_phase]}, el);
		cur_phase = nxt;
	endtask

	task automatic send_command(input cmd_t cmd);
		send_item(cmd, 4'($urandom), 28'($urandom));
	endtask

	// Drop valid and wait until every expected result has come out
	task automatic stop_and_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Register write: setup, then access
	task automatic write_mode(input logic x4);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MODE_ADDR;
		pwdata  <= {31'd0, x4};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic logic [27:0] draw_elapsed();
		case ($urandom_range(0, 9))
			0, 1:    return 28'($urandom_range(0, 15));
			2:       return ELAPSED_MAX;
			3, 4:    return 28'($urandom_range(0, 1000));
			default: return 28'($urandom);
		endcase
	endfunction

	// Mostly a clean walk round the phases with the odd reversal; mix in
	// dither, double steps, corrupted reports and the other commands
	task automatic send_random();
		int pick;
		logic [1:0] nxt;
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			send_command(CMD_CAPTURE);
		end else if (pick < 9) begin
			send_command(CMD_ZERO);
		end else if (pick < 11) begin
			send_command(CMD_UNUSED);
		end else if (pick < 13) begin
			// long dither at full elapsed: in x1 mode, drive the pending time into saturation
			repeat (9) step_to(cur_phase, ELAPSED_MAX);
		end else if (pick < 18) begin
			// report whose previous levels are random and may disagree with the tracked phase
			nxt = 2'($urandom);
			send_item(CMD_TRANSITION, {PINS_BY_PHASE[nxt], 2'($urandom)}, draw_elapsed());
			cur_phase = nxt;
		end else if (pick < 22) begin
			step_to(cur_phase, ($urandom_range(0, 1) == 0) ? ELAPSED_MAX : draw_elapsed());
		end else if (pick < 26) begin
			step_to(cur_phase + 2'd2, draw_elapsed());
		end else begin
			if ($urandom_range(0, 9) == 0) walk_up = !walk_up;
			step_to(walk_up ? cur_phase + 2'd1 : cur_phase - 2'd1, draw_elapsed());
		end
	endtask

	// Result side: random stalls per result, plus one long hold on request
	initial begin : result_sink
		int wait_cycles;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (sink_hold) begin
				wait_cycles = LONG_HOLD;
				sink_hold = 1'b0;
			end else begin
				wait_cycles = sink_steady ? 0 : $urandom_range(0, 17);
			end
			if (wait_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin : stimulus
		int p;
		int k;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= CMD_TRANSITION;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// x4: nine up steps at full elapsed saturate the window, so the
		// capture reports a change with the rate flag clear
		write_mode(1'b1);
		repeat (9) step_to(cur_phase + 2'd1, ELAPSED_MAX);
		send_command(CMD_CAPTURE);
		step_to(cur_phase - 2'd1, 28'd0);
		step_to(cur_phase - 2'd1, 28'd1);
		step_to(cur_phase, 28'd7);
		step_to(cur_phase + 2'd2, 28'd9);
		send_command(CMD_CAPTURE);
		send_command(CMD_ZERO);
		send_command(CMD_UNUSED);
		stop_and_drain();

		// x1: up detents with the direction still latched up from the x4 steps, then one
		// down, and a half detent that turns back without counting
		write_mode(1'b0);
		step_to(cur_phase + 2'd1, draw_elapsed());
		while (cur_phase != 2'd1) step_to(cur_phase + 2'd1, draw_elapsed());
		step_to(2'd2, draw_elapsed());
		step_to(2'd3, draw_elapsed());
		step_to(2'd0, draw_elapsed());
		step_to(2'd1, draw_elapsed());
		step_to(2'd2, draw_elapsed());
		step_to(2'd1, draw_elapsed());
		step_to(2'd0, draw_elapsed());
		step_to(2'd3, draw_elapsed());
		step_to(2'd2, draw_elapsed());
		step_to(2'd3, draw_elapsed());
		step_to(2'd2, draw_elapsed());
		send_command(CMD_CAPTURE);

		// Random phases, alternating the counting mode
		for (p = 0; p < RANDOM_PHASES; p++) begin
			stop_and_drain();
			write_mode(p[0]);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 45 == 0) begin
					feed_steady = ($urandom_range(0, 3) == 0);
					sink_steady = ($urandom_range(0, 3) == 0);
				end
				// Hold the results back while items keep coming, to fill the queue
				if (p == 1 && k == 20) begin
					sink_hold   = 1'b1;
					feed_steady = 1'b1;
				end
				// Pause the feed until everything has come out
				if (p == 2 && k == 70) stop_and_drain();
				send_random();
			end
		end

		stop_and_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("** quadrature_decoder_with_timing: PASSED **");
		end else begin
			$display("** quadrature_decoder_with_timing: FAILED **");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/qdt_pkg.sv
rtl/core/qdt_front.sv
rtl/core/qdt_queue.sv
rtl/core/qdt_back.sv
rtl/core/quadrature_decoder_with_timing.sv
sim/quadrature_decoder_with_timing_checker.sv
sim/quadrature_decoder_with_timing_test.sv
